// ===== sv/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rsa_pkg: shared constants for the RGB saturation adjust block
// Channel default width, gain format and perceived-brightness weights.
// ----------------------------------------------------------------------------
package rsa_pkg;

    // Default channel width in bits (unsigned Q0.CHANNEL_BITS).
    localparam int CHANNEL_BITS_DEF = 16;

    // Saturation gain register, unsigned Q4.8.
    localparam int GAIN_BITS = 12;
    localparam int GAIN_FRAC_BITS = 8;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 12'd256;

    // Brightness weights in unsigned Q0.16; they sum to exactly 65536.
    localparam int WEIGHT_BITS = 16;
    localparam logic [2:0][WEIGHT_BITS-1:0] WEIGHTS = {16'd7471, 16'd38470, 16'd19595};

    // Channel order inside packed pixel vectors.
    localparam int CH_RED = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE = 2;
    localparam int NUM_CH = 3;

endpackage

// ===== sv/rsa_in_if.sv =====
// ----------------------------------------------------------------------------
// rsa_in_if: input pixel channel
// Valid/ready channel carrying one RGB pixel word and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface rsa_in_if #(
    parameter int CHANNEL_BITS = rsa_pkg::CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
    logic                    frame_end_in;

    modport source (
        output valid, red_in, green_in, blue_in, frame_end_in,
        input  ready
    );

    modport sink (
        input  valid, red_in, green_in, blue_in, frame_end_in,
        output ready
    );
endinterface

// ===== sv/rsa_out_if.sv =====
// ----------------------------------------------------------------------------
// rsa_out_if: output pixel channel
// Valid/ready channel carrying one adjusted pixel word with its flags.
// ----------------------------------------------------------------------------
interface rsa_out_if #(
    parameter int CHANNEL_BITS = rsa_pkg::CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
    logic                    clipped;
    logic                    frame_end_out;

    modport source (
        output valid, red_out, green_out, blue_out, clipped, frame_end_out,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out, clipped, frame_end_out,
        output ready
    );
endinterface

// ===== sv/rsa_luma.sv =====
// ----------------------------------------------------------------------------
// rsa_luma: weighted sum of squared channels
// Three stages: square each channel, scale by its weight, add the three terms.
// ----------------------------------------------------------------------------
module rsa_luma #(
    parameter int CHANNEL_BITS = rsa_pkg::CHANNEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0][CHANNEL_BITS-1:0] i_pix,
    input  logic                         i_frame_end,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [2*CHANNEL_BITS-1:0]    o_sum,
    output logic [2:0][CHANNEL_BITS-1:0] o_pix,
    output logic                         o_frame_end
);
    import rsa_pkg::*;

    localparam int SQ_W = 2 * CHANNEL_BITS;
    localparam int PROD_W = SQ_W + WEIGHT_BITS;

    logic                         r_v0, r_v1, r_v2;
    logic                         w_en0, w_en1, w_en2;
    logic [SQ_W-1:0]              r_sq [NUM_CH];
    logic [PROD_W-1:0]            r_wp [NUM_CH];
    logic [PROD_W-1:0]            r_sum;
    logic [2:0][CHANNEL_BITS-1:0] r_pix0, r_pix1, r_pix2;
    logic                         r_fe0, r_fe1, r_fe2;

    // A stage loads when it is empty or its word moves on.
    assign w_en2 = !r_v2 || i_ready;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en0 = !r_v0 || w_en1;
    assign o_ready = w_en0;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en0) r_v0 <= i_valid;
            if (w_en1) r_v1 <= r_v0;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    // Stage 0 squares each channel.
    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_sq[k] <= SQ_W'(i_pix[k]) * SQ_W'(i_pix[k]);
            end
            r_pix0 <= i_pix;
            r_fe0  <= i_frame_end;
        end
    end

    // Stage 1 scales each square by its brightness weight.
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_wp[k] <= PROD_W'(r_sq[k]) * PROD_W'(WEIGHTS[k]);
            end
            r_pix1 <= r_pix0;
            r_fe1  <= r_fe0;
        end
    end

    // Stage 2 adds the terms; the weights sum to one, so nothing overflows.
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_sum  <= r_wp[CH_RED] + r_wp[CH_GREEN] + r_wp[CH_BLUE];
            r_pix2 <= r_pix1;
            r_fe2  <= r_fe1;
        end
    end

    assign o_valid     = r_v2;
    assign o_sum       = r_sum[PROD_W-1:WEIGHT_BITS];
    assign o_pix       = r_pix2;
    assign o_frame_end = r_fe2;

endmodule

// ===== sv/rsa_sqrt.sv =====
// ----------------------------------------------------------------------------
// rsa_sqrt: pipelined integer square root
// One root bit per stage, restoring digit recurrence, CHANNEL_BITS stages.
// ----------------------------------------------------------------------------
module rsa_sqrt #(
    parameter int CHANNEL_BITS = rsa_pkg::CHANNEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2*CHANNEL_BITS-1:0]    i_rad,
    input  logic [2:0][CHANNEL_BITS-1:0] i_pix,
    input  logic                         i_frame_end,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [CHANNEL_BITS-1:0]      o_root,
    output logic [2:0][CHANNEL_BITS-1:0] o_pix,
    output logic                         o_frame_end
);
    import rsa_pkg::*;

    localparam int NS = CHANNEL_BITS;
    localparam int RAD_W = 2 * CHANNEL_BITS;
    localparam int REM_W = CHANNEL_BITS + 2;
    localparam int TMP_W = REM_W + 2;

    logic [NS-1:0]                r_v;
    logic [NS-1:0]                w_en;
    logic [RAD_W-1:0]             r_rad  [NS];
    logic [REM_W-1:0]             r_rem  [NS];
    logic [CHANNEL_BITS-1:0]      r_root [NS];
    logic [2:0][CHANNEL_BITS-1:0] r_pix  [NS];
    logic [NS-1:0]                r_fe;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic                         w_src_v;
        logic [RAD_W-1:0]             w_src_rad;
        logic [REM_W-1:0]             w_src_rem;
        logic [CHANNEL_BITS-1:0]      w_src_root;
        logic [2:0][CHANNEL_BITS-1:0] w_src_pix;
        logic                         w_src_fe;
        logic [TMP_W-1:0]             w_tmp;
        logic [TMP_W-1:0]             w_trial;
        logic                         w_ge;

        // Stage inputs come from the port or from the previous stage.
        if (k == 0) begin : g_first
            assign w_src_v    = i_valid;
            assign w_src_rad  = i_rad;
            assign w_src_rem  = '0;
            assign w_src_root = '0;
            assign w_src_pix  = i_pix;
            assign w_src_fe   = i_frame_end;
        end else begin : g_next
            assign w_src_v    = r_v[k-1];
            assign w_src_rad  = r_rad[k-1];
            assign w_src_rem  = r_rem[k-1];
            assign w_src_root = r_root[k-1];
            assign w_src_pix  = r_pix[k-1];
            assign w_src_fe   = r_fe[k-1];
        end

        // Stall chain: the last stage looks at the downstream ready.
        if (k == NS - 1) begin : g_last_en
            assign w_en[k] = !r_v[k] || i_ready;
        end else begin : g_mid_en
            assign w_en[k] = !r_v[k] || w_en[k+1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign w_tmp   = {w_src_rem, w_src_rad[RAD_W-1 -: 2]};
        assign w_trial = TMP_W'({w_src_root, 2'b01});
        assign w_ge    = (w_tmp >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_rad[k] <= {w_src_rad[RAD_W-3:0], 2'b00};
                if (w_ge) begin
                    r_rem[k]  <= REM_W'(w_tmp - w_trial);
                    r_root[k] <= {w_src_root[CHANNEL_BITS-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= REM_W'(w_tmp);
                    r_root[k] <= {w_src_root[CHANNEL_BITS-2:0], 1'b0};
                end
                r_pix[k] <= w_src_pix;
                r_fe[k]  <= w_src_fe;
            end
        end
    end

    assign o_ready     = w_en[0];
    assign o_valid     = r_v[NS-1];
    assign o_root      = r_root[NS-1];
    assign o_pix       = r_pix[NS-1];
    assign o_frame_end = r_fe[NS-1];

endmodule

// ===== sv/rsa_adjust.sv =====
// ----------------------------------------------------------------------------
// rsa_adjust: move each channel about the brightness by the gain
// Stage 0 multiplies the channel distance by the gain; stage 1 adds the
// brightness, rounds to nearest and saturates to the channel range.
// ----------------------------------------------------------------------------
module rsa_adjust #(
    parameter int CHANNEL_BITS = rsa_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rsa_pkg::GAIN_BITS-1:0] i_gain,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [CHANNEL_BITS-1:0]       i_p,
    input  logic [2:0][CHANNEL_BITS-1:0]  i_pix,
    input  logic                          i_frame_end,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0][CHANNEL_BITS-1:0]  o_pix,
    output logic                          o_clipped,
    output logic                          o_frame_end
);
    import rsa_pkg::*;

    localparam int PW = CHANNEL_BITS + GAIN_BITS + 2;
    localparam int VW = PW + 1;
    localparam int Q_W = VW - 1 - GAIN_FRAC_BITS;
    localparam logic signed [VW-1:0] HALF = VW'(1 << (GAIN_FRAC_BITS - 1));

    logic                         r_v0, r_v1;
    logic                         w_en0, w_en1;
    logic signed [GAIN_BITS:0]    w_g;
    logic signed [CHANNEL_BITS:0] w_d [NUM_CH];
    logic signed [PW-1:0]         r_prod [NUM_CH];
    logic [CHANNEL_BITS-1:0]      r_p0;
    logic                         r_fe0;
    logic signed [VW-1:0]         w_v [NUM_CH];
    logic [Q_W-1:0]               w_q [NUM_CH];
    logic [2:0][CHANNEL_BITS-1:0] w_sat;
    logic [NUM_CH-1:0]            w_clip;
    logic [2:0][CHANNEL_BITS-1:0] r_out;
    logic                         r_clip;
    logic                         r_fe1;

    assign w_en1   = !r_v1 || i_ready;
    assign w_en0   = !r_v0 || w_en1;
    assign o_ready = w_en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_en0) r_v0 <= i_valid;
            if (w_en1) r_v1 <= r_v0;
        end
    end

    // Signed distance of each channel from the brightness.
    always_comb begin
        w_g = $signed({1'b0, i_gain});
        for (int k = 0; k < NUM_CH; k++) begin
            w_d[k] = $signed({1'b0, i_pix[k]}) - $signed({1'b0, i_p});
        end
    end

    // Stage 0 scales the distances by the gain.
    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_prod[k] <= PW'(w_d[k]) * PW'(w_g);
            end
            r_p0  <= i_p;
            r_fe0 <= i_frame_end;
        end
    end

    // Add the brightness and the rounding half, then clamp to the range.
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            w_v[k] = VW'($signed({1'b0, r_p0, {GAIN_FRAC_BITS{1'b0}}}))
                   + VW'(r_prod[k]) + HALF;
            w_q[k] = w_v[k][VW-2:GAIN_FRAC_BITS];
            if (w_v[k][VW-1]) begin
                w_sat[k]  = '0;
                w_clip[k] = 1'b1;
            end else if (|w_q[k][Q_W-1:CHANNEL_BITS]) begin
                w_sat[k]  = '1;
                w_clip[k] = 1'b1;
            end else begin
                w_sat[k]  = w_q[k][CHANNEL_BITS-1:0];
                w_clip[k] = 1'b0;
            end
        end
    end

    // Stage 1 holds the finished word until it is taken.
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_out  <= w_sat;
            r_clip <= |w_clip;
            r_fe1  <= r_fe0;
        end
    end

    assign o_valid     = r_v1;
    assign o_pix       = r_out;
    assign o_clipped   = r_clip;
    assign o_frame_end = r_fe1;

endmodule

// ===== sv/rgb_saturation_adjust.sv =====
// ----------------------------------------------------------------------------
// rgb_saturation_adjust: perceived-brightness saturation adjustment
// Scales each RGB channel's distance from the perceived brightness by a gain.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix is the input word channel (red, green, blue, end-of-frame mark) and
//   o_pix the result channel; both use valid/ready and move a word at an edge
//   where both are high. The saturation gain (unsigned Q4.8, 256 is neutral)
//   is written through i_cfg_we/i_cfg_wdata while the pipeline is empty.
//   From input to output a word passes three stages for the weighted sum of
//   squares, one stage per root bit in the square-root pipeline, and two for
//   the gain multiply and the rounding and clamp.
//   Throughput is one word per cycle while the receiver keeps taking words;
//   every stage holds a valid bit and loads whenever it is empty or its word
//   moves on, so bubbles close up.
//   When the receiver stalls, words stack up in the stages and i_pix.ready
//   falls only once every stage is full; nothing is dropped or repeated.
//   Reset clears all valid bits and sets the gain to 256.
//   The clipped flag is set when any channel was clamped to 0 or full scale.
// ----------------------------------------------------------------------------
module rgb_saturation_adjust #(
    parameter int CHANNEL_BITS = rsa_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rsa_pkg::GAIN_BITS-1:0] i_cfg_wdata,
    rsa_in_if.sink                        i_pix,
    rsa_out_if.source                     o_pix
);
    import rsa_pkg::*;

    logic [GAIN_BITS-1:0]         r_gain;

    logic [2:0][CHANNEL_BITS-1:0] w_in_pix;
    logic                         w_l_valid, w_l_ready;
    logic [2*CHANNEL_BITS-1:0]    w_l_sum;
    logic [2:0][CHANNEL_BITS-1:0] w_l_pix;
    logic                         w_l_fe;
    logic                         w_s_valid, w_s_ready;
    logic [CHANNEL_BITS-1:0]      w_s_root;
    logic [2:0][CHANNEL_BITS-1:0] w_s_pix;
    logic                         w_s_fe;
    logic [2:0][CHANNEL_BITS-1:0] w_out_pix;

    // Saturation gain register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    // Pack the input channels in red, green, blue order.
    always_comb begin
        w_in_pix[CH_RED]   = i_pix.red_in;
        w_in_pix[CH_GREEN] = i_pix.green_in;
        w_in_pix[CH_BLUE]  = i_pix.blue_in;
    end

    // Weighted sum of squared channels.
    rsa_luma #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_luma (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_pix.valid),
        .o_ready     (i_pix.ready),
        .i_pix       (w_in_pix),
        .i_frame_end (i_pix.frame_end_in),
        .o_valid     (w_l_valid),
        .i_ready     (w_l_ready),
        .o_sum       (w_l_sum),
        .o_pix       (w_l_pix),
        .o_frame_end (w_l_fe)
    );

    // Perceived brightness as the floor of the square root.
    rsa_sqrt #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_sqrt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_l_valid),
        .o_ready     (w_l_ready),
        .i_rad       (w_l_sum),
        .i_pix       (w_l_pix),
        .i_frame_end (w_l_fe),
        .o_valid     (w_s_valid),
        .i_ready     (w_s_ready),
        .o_root      (w_s_root),
        .o_pix       (w_s_pix),
        .o_frame_end (w_s_fe)
    );

    // Gain, rounding and saturation.
    rsa_adjust #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_adjust (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain      (r_gain),
        .i_valid     (w_s_valid),
        .o_ready     (w_s_ready),
        .i_p         (w_s_root),
        .i_pix       (w_s_pix),
        .i_frame_end (w_s_fe),
        .o_valid     (o_pix.valid),
        .i_ready     (o_pix.ready),
        .o_pix       (w_out_pix),
        .o_clipped   (o_pix.clipped),
        .o_frame_end (o_pix.frame_end_out)
    );

    assign o_pix.red_out   = w_out_pix[CH_RED];
    assign o_pix.green_out = w_out_pix[CH_GREEN];
    assign o_pix.blue_out  = w_out_pix[CH_BLUE];

    // A clipped word has at least one channel at zero or full scale.
    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && o_pix.clipped |->
            (o_pix.red_out == '0)   || (o_pix.red_out == '1)   ||
            (o_pix.green_out == '0) || (o_pix.green_out == '1) ||
            (o_pix.blue_out == '0)  || (o_pix.blue_out == '1))
        else $error("clipped word has no channel at a limit");

    // With the output stage empty, the stall chain must let a word in.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pix.valid |-> i_pix.ready)
        else $error("input stalled while the output stage is empty");

    // The cycle after reset no result word is offered.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("result word offered right after reset");

endmodule
